@@ src/amx_pkg.sv @@
package amx_pkg;

  localparam int MODE_W  = 3;
  localparam int VERTEX_W = 8;
  localparam int RESULT_W = 9;

  localparam logic [MODE_W-1:0] MODE_ADD_EDGE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEL_EDGE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADJACENT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_IN_DEG    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OUT_DEG   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ADD_VERT  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DEL_VERT  = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input request
    logic init;    // set up the clearing pass after reset
    logic start;   // decode the request, issue the row read, set up a walk
    logic row;     // row data is back: edge write, adjacency bit, hold row
    logic walk;    // advance the row walk
    logic finish;  // load the result register and commit the count
  } cmd_t;

  typedef struct packed {
    logic use_row;
    logic use_walk;
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

@@ src/amx_ctrl.sv @@
module amx_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  amx_pkg::status_t status,
  output amx_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_IDLE     = 3'd2;
  localparam logic [2:0] S_DISPATCH = 3'd3;
  localparam logic [2:0] S_ROW      = 3'd4;
  localparam logic [2:0] S_WALK     = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.start = 1'b1;
        if (status.use_row) begin
          state_nxt = S_ROW;
        end else if (status.use_walk) begin
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_ROW: begin
        cmd.row   = 1'b1;
        state_nxt = status.use_walk ? S_WALK : S_FINISH;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/amx_datapath.sv @@
module amx_datapath #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  amx_pkg::cmd_t                     cmd,
  output amx_pkg::status_t                  status,
  input  logic [amx_pkg::MODE_W-1:0]        in_mode,
  input  logic [amx_pkg::VERTEX_W-1:0]      in_vertex_a,
  input  logic [amx_pkg::VERTEX_W-1:0]      in_vertex_b,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [amx_pkg::RESULT_W-1:0]      out_result_value,
  output logic [amx_pkg::RESULT_W-1:0]      out_live_count,
  output logic                              out_error_flag
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int RW = amx_pkg::RESULT_W;

  // Edge matrix, one row per vertex, bit j of row i is the edge i->j.
  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rd_q;

  logic [amx_pkg::MODE_W-1:0]   mode_r;
  logic [amx_pkg::VERTEX_W-1:0] a_r;
  logic [amx_pkg::VERTEX_W-1:0] b_r;
  logic [CW-1:0]                count_r;
  logic [IW-1:0]                lo_r;
  logic [IW-1:0]                lim_r;
  logic [CW-1:0]                end_r;
  logic [CW-1:0]                idx_r;
  logic [IW-1:0]                widx_r;
  logic                         wvalid_r;
  logic                         deg_r;
  logic [CW-1:0]                value_r;
  logic [MAX_VERTICES-1:0]      hold_r;
  logic                         out_valid_r;
  logic [RW-1:0]                out_value_r;
  logic [RW-1:0]                out_count_r;
  logic                         out_err_r;

  logic [RW-1:0]           count9;
  logic [RW-1:0]           a9;
  logic [RW-1:0]           b9;
  logic [RW-1:0]           a1;
  logic                    a_ok;
  logic                    b_ok;
  logic                    err;
  logic                    trunc;
  logic [CW-1:0]           cnt_m1;
  logic [CW-1:0]           count_nxt;
  logic [IW-1:0]           idx_lo;
  logic [IW-1:0]           a_lo;
  logic [IW-1:0]           b_lo;
  logic                    issue;
  logic                    rd_en;
  logic [IW-1:0]           rd_addr;
  logic [IW-1:0]           src_row;
  logic [MAX_VERTICES-1:0] shifted;
  logic [MAX_VERTICES-1:0] fixed;
  logic [MAX_VERTICES-1:0] edge_row;
  logic                    we;
  logic [IW-1:0]           waddr;
  logic [MAX_VERTICES-1:0] wdata;
  logic                    deg_bit;

  assign count9 = RW'(count_r);
  assign a9     = {1'b0, a_r};
  assign b9     = {1'b0, b_r};
  assign a1     = a9 + RW'(1);
  assign a_ok   = a9 < count9;
  assign b_ok   = b9 < count9;
  assign cnt_m1 = count_r - CW'(1);
  assign idx_lo = idx_r[IW-1:0];
  assign a_lo   = a_r[IW-1:0];
  assign b_lo   = b_r[IW-1:0];

  always_comb begin
    unique case (mode_r)
      amx_pkg::MODE_ADD_EDGE,
      amx_pkg::MODE_DEL_EDGE,
      amx_pkg::MODE_ADJACENT: err = !(a_ok && b_ok);
      amx_pkg::MODE_IN_DEG,
      amx_pkg::MODE_OUT_DEG,
      amx_pkg::MODE_DEL_VERT: err = !a_ok;
      amx_pkg::MODE_ADD_VERT: err = a1 > RW'(MAX_VERTICES);
      default:                err = 1'b0;
    endcase
  end

  // Shrinking the count must wipe the rows and columns past the new count.
  assign trunc = (mode_r == amx_pkg::MODE_ADD_VERT) && !err && (a1 < count9);

  assign status.use_row = !err && ((mode_r == amx_pkg::MODE_ADD_EDGE) ||
                                   (mode_r == amx_pkg::MODE_DEL_EDGE) ||
                                   (mode_r == amx_pkg::MODE_ADJACENT) ||
                                   (mode_r == amx_pkg::MODE_OUT_DEG));
  assign status.use_walk = !err && ((mode_r == amx_pkg::MODE_IN_DEG) ||
                                    (mode_r == amx_pkg::MODE_OUT_DEG) ||
                                    (mode_r == amx_pkg::MODE_DEL_VERT) || trunc);
  assign status.walk_done = (idx_r >= end_r) && !wvalid_r;
  assign status.out_free  = !out_valid_r || out_ready;

  always_comb begin
    if (err) begin
      count_nxt = count_r;
    end else if (mode_r == amx_pkg::MODE_ADD_VERT) begin
      count_nxt = CW'(a1);
    end else if (mode_r == amx_pkg::MODE_DEL_VERT) begin
      count_nxt = cnt_m1;
    end else begin
      count_nxt = count_r;
    end
  end

  // Walk: each row is written back in the cycle after it is read. Rows from
  // lo up to lim take their contents from the row below, which has not been
  // overwritten yet because the write trails the read by one row.
  assign issue   = cmd.walk && (idx_r < end_r);
  assign src_row = ((idx_lo >= lo_r) && (idx_lo < lim_r)) ? idx_lo + IW'(1) : idx_lo;
  assign rd_en   = cmd.start || issue;
  assign rd_addr = cmd.start ? a_lo : src_row;

  assign shifted = rd_q >> 1;

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if (IW'(j) >= lim_r) begin
        fixed[j] = 1'b0;
      end else if (IW'(j) < lo_r) begin
        fixed[j] = rd_q[j];
      end else begin
        fixed[j] = shifted[j];
      end
    end
  end

  always_comb begin
    edge_row       = rd_q;
    edge_row[b_lo] = (mode_r == amx_pkg::MODE_ADD_EDGE);
  end

  always_comb begin
    we    = 1'b0;
    waddr = widx_r;
    wdata = (widx_r >= lim_r) ? '0 : fixed;
    if (cmd.row && ((mode_r == amx_pkg::MODE_ADD_EDGE) ||
                    (mode_r == amx_pkg::MODE_DEL_EDGE))) begin
      we    = 1'b1;
      waddr = a_lo;
      wdata = edge_row;
    end else if (wvalid_r && !deg_r) begin
      we = 1'b1;
    end
  end

  assign deg_bit = (mode_r == amx_pkg::MODE_IN_DEG) ? rd_q[a_lo] : hold_r[widx_r];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      a_r    <= in_vertex_a;
      b_r    <= in_vertex_b;
    end
    if (cmd.row) begin
      hold_r <= rd_q;
    end
    if (cmd.start) begin
      lo_r    <= '0;
      lim_r   <= '0;
      deg_r   <= 1'b1;
      end_r   <= count_r;
      value_r <= '0;
      if (mode_r == amx_pkg::MODE_DEL_VERT) begin
        deg_r <= 1'b0;
        lo_r  <= a_lo;
        lim_r <= cnt_m1[IW-1:0];
      end else if (mode_r == amx_pkg::MODE_ADD_VERT) begin
        deg_r <= 1'b0;
        lo_r  <= a1[IW-1:0];
        lim_r <= a1[IW-1:0];
      end
    end else if (cmd.init) begin
      lo_r  <= '0;
      lim_r <= '0;
      deg_r <= 1'b0;
      end_r <= CW'(MAX_VERTICES);
    end else if (cmd.row && (mode_r == amx_pkg::MODE_ADJACENT)) begin
      value_r <= CW'(rd_q[b_lo]);
    end else if (wvalid_r && deg_r) begin
      value_r <= value_r + CW'(deg_bit);
    end
    if (issue) begin
      widx_r <= idx_lo;
    end
    if (cmd.finish) begin
      out_value_r <= RW'(value_r);
      out_count_r <= RW'(count_nxt);
      out_err_r   <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      wvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wvalid_r <= issue;
      if (cmd.start || cmd.init) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.finish) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_live_count   = out_count_r;
  assign out_error_flag   = out_err_r;

endmodule

@@ src/adjacency_matrix_store_top.sv @@
// Channel   Direction  Handshake             Payload
// in_       request    in_valid / in_ready   in_mode, in_vertex_a, in_vertex_b
// out_      result     out_valid / out_ready out_result_value, out_live_count,
//                                            out_error_flag
//
// Edge set, edge clear and adjacency test go through the dispatch, row and finish
// steps. In-degree, vertex removal and count truncation walk the live rows through
// the matrix memory, which has one read and one write port; out-degree reads its
// row first and then walks. Errors, growing the count and unused modes go
// straight from dispatch to finish. Requests are taken one at a time.
// After reset a clearing pass over all MAX_VERTICES rows runs before in_ready rises.
// A stalled result stays in the output register; the next request is accepted
// meanwhile, and its result waits in the finish step until the register frees.
module adjacency_matrix_store_top #(
  parameter int MAX_VERTICES = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [amx_pkg::MODE_W-1:0]   in_mode,
  input  logic [amx_pkg::VERTEX_W-1:0] in_vertex_a,
  input  logic [amx_pkg::VERTEX_W-1:0] in_vertex_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [amx_pkg::RESULT_W-1:0] out_result_value,
  output logic [amx_pkg::RESULT_W-1:0] out_live_count,
  output logic                         out_error_flag
);

  amx_pkg::cmd_t    cmd;
  amx_pkg::status_t status;

  amx_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  amx_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_mode          (in_mode),
    .in_vertex_a      (in_vertex_a),
    .in_vertex_b      (in_vertex_b),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_result_value (out_result_value),
    .out_live_count   (out_live_count),
    .out_error_flag   (out_error_flag)
  );

endmodule

@@ src/amx_checker.sv @@
module amx_checker #(
  parameter int MAX_VERTICES = 32
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [amx_pkg::RESULT_W-1:0] out_result_value,
  input logic [amx_pkg::RESULT_W-1:0] out_live_count,
  input logic                         out_error_flag
);

  localparam logic [amx_pkg::RESULT_W-1:0] MaxCount = amx_pkg::RESULT_W'(MAX_VERTICES);

  // One request at a time: ready drops right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
                                $stable(out_live_count) && $stable(out_error_flag))
    else $error("stalled result changed or was dropped");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_result_value == '0)
    else $error("error result carries a nonzero value");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_live_count <= MaxCount)
    else $error("live count exceeds capacity");

  // A degree or adjacency bit can never exceed the number of live vertices.
  a_value_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error_flag |-> out_result_value <= out_live_count)
    else $error("result value exceeds the live count");

endmodule

bind adjacency_matrix_store_top amx_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_amx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_live_count   (out_live_count),
  .out_error_flag   (out_error_flag)
);
